### rtl/core/afm_pkg.sv
package afm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 31;
    localparam int MAG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES = 1'd1;

    localparam logic [MAG_W-1:0] MEAN_CAP = 16'd32768;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_READ,
        t_ST_SAMPLE,
        t_ST_DIV,
        t_ST_FRAME,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sample_go;
        logic report;
        logic div_start;
        logic frame_go;
    } t_cmd;

    typedef struct packed {
        logic is_cmd;
        logic is_last;
        logic div_done;
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0] seq_of_frame;
        logic [MAG_W-1:0] mean_magnitude;
        logic [MAG_W-1:0] peak_magnitude;
        logic             is_repeat;
        logic [CNT_W-1:0] repeat_run;
        logic [CNT_W-1:0] total_frames;
        logic [CNT_W-1:0] window_frames;
        logic [CNT_W-1:0] total_repeats;
        logic [CNT_W-1:0] window_repeats;
        logic [CNT_W-1:0] window_run_max;
        logic [MAG_W-1:0] window_mean_max;
        logic [MAG_W-1:0] window_peak_max;
    } t_result;

endpackage

### rtl/core/audio_frame_level_and_repeat_monitor.sv
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata {frame_number,sample}, tuser command,
//          |     |                           | tlast last_sample
// m_axis   | out | m_axis_tvalid/tready      | tdata result fields
// cfg      | in  | i_cfg_valid/o_cfg_ready   | i_cfg_index, i_cfg_data
// A sample that does not end a frame passes through accept, store read and update.
// A frame end then runs the shift-subtract divider for the mean, a frame update and a load.
// A report command passes through accept, decode and result load. The output register
// holds the result until taken; the next beat is accepted once it has been loaded there.
// Reset is synchronous, active low; the frame store needs no clearing.
module audio_frame_level_and_repeat_monitor #(
    parameter int FRAME_STORE_DEPTH = 1024,
    parameter int FRAME_COUNT_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // sample[15:0], frame_number[47:16]
    input  logic         s_axis_tuser,   // command
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // seq_of_frame, mean_magnitude, peak_magnitude, is_repeat, repeat_run,
    // total_frames, window_frames, total_repeats, window_repeats,
    // window_run_max, window_mean_max, window_peak_max; zero-filled to 296 bits
    output logic [295:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import afm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;
    logic    w_out_load;
    logic    r_out_valid;
    t_result r_out;

    afm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (!r_out_valid || m_axis_tready),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    afm_dp #(
        .FRAME_STORE_DEPTH (FRAME_STORE_DEPTH),
        .FRAME_COUNT_BITS  (FRAME_COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cmd_bit      (s_axis_tuser),
        .i_sample       (s_axis_tdata[15:0]),
        .i_last         (s_axis_tlast),
        .i_frame_number (s_axis_tdata[47:16]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_idx      (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (w_status),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.window_peak_max, r_out.window_mean_max,
                            r_out.window_run_max, r_out.window_repeats,
                            r_out.total_repeats, r_out.window_frames,
                            r_out.total_frames, r_out.repeat_run, r_out.is_repeat,
                            r_out.peak_magnitude, r_out.mean_magnitude,
                            r_out.seq_of_frame};

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !r_out_valid || m_axis_tready)
        else $error("result overwritten");
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_out_load)
        else $error("accept during result load");
`endif

endmodule

### rtl/core/afm_ctrl.sv
module afm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  afm_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_load,
    output afm_pkg::t_cmd    o_cmd
);
    import afm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd      = '0;
        case (r_state)
            t_ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = t_ST_READ;
                end
            end
            t_ST_READ: begin
                if (i_status.is_cmd) begin
                    n_state = t_ST_OUT;
                end else begin
                    n_state = t_ST_SAMPLE;
                end
            end
            t_ST_SAMPLE: begin
                o_cmd.sample_go = 1'b1;
                if (i_status.is_last) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = t_ST_DIV;
                end else begin
                    n_state = t_ST_IDLE;
                end
            end
            t_ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = t_ST_FRAME;
                end
            end
            t_ST_FRAME: begin
                o_cmd.frame_go = 1'b1;
                n_state        = t_ST_OUT;
            end
            t_ST_OUT: begin
                if (i_out_free) begin
                    o_out_load   = 1'b1;
                    o_cmd.report = i_status.is_cmd;
                    n_state      = t_ST_IDLE;
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

endmodule

### rtl/core/afm_div.sv
module afm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [afm_pkg::SUM_W-1:0] i_num,
    input  logic [afm_pkg::SUM_W-1:0] i_den,
    output logic                      o_done,
    output logic [afm_pkg::SUM_W-1:0] o_quo
);
    import afm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [SUM_W:0]    r_rem, n_rem;
    logic [SUM_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [SUM_W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem[SUM_W-1:0], r_quo[SUM_W-1]};
        n_quo   = {r_quo[SUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;

endmodule

### rtl/core/afm_dp.sv
module afm_dp #(
    parameter int FRAME_STORE_DEPTH = 1024,
    parameter int FRAME_COUNT_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  afm_pkg::t_cmd                i_cmd,
    input  logic                         i_cmd_bit,
    input  logic [afm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_last,
    input  logic [afm_pkg::CNT_W-1:0]    i_frame_number,
    input  logic                         i_cfg_we,
    input  logic [afm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                  i_cfg_data,
    output afm_pkg::t_status             o_status,
    output afm_pkg::t_result             o_result
);
    import afm_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_STORE_DEPTH);
    localparam logic [FRAME_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [SAMPLE_W-1:0] r_mem [FRAME_STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd;

    logic                  r_is_cmd, r_last;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [CNT_W-1:0]      r_fnum;
    logic [15:0]           r_min_peak;
    logic [10:0]           r_max_samples;
    logic [10:0]           r_prev_len;
    logic [MAG_W-1:0]      r_prev_peak;
    logic [CNT_W-1:0]      r_run;
    logic [FRAME_COUNT_BITS-1:0] r_count;
    logic [SUM_W-1:0]      r_sum;
    logic [MAG_W-1:0]      r_peak;
    logic                  r_mis;
    logic                  r_rep;
    logic [CNT_W-1:0]      r_tot_f, r_win_f, r_tot_r, r_win_r, r_win_run;
    logic [CNT_W-1:0]      r_seq;
    logic [MAG_W-1:0]      r_mean, r_rpeak, r_win_mean, r_win_peak;

    logic [MAG_W-1:0]      w_mag;
    logic [SUM_W:0]        w_sum;
    logic                  w_in_store;
    logic [ADDR_W-1:0]     w_addr;
    logic [SUM_W-1:0]      w_quo;
    logic                  w_done;
    logic [MAG_W-1:0]      w_mean;
    logic                  w_long, w_rep;
    logic [CNT_W-1:0]      w_run_inc;

    assign w_in_store = CNT_W'(r_count) < CNT_W'(FRAME_STORE_DEPTH);
    assign w_addr     = r_count[ADDR_W-1:0];
    assign w_mag      = r_sample[SAMPLE_W-1] ? MAG_W'(~r_sample + 1'b1) : r_sample;
    assign w_sum      = {1'b0, r_sum} + (SUM_W+1)'(w_mag);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_mem[w_addr];
        end
        if (i_cmd.sample_go && w_in_store) begin
            r_mem[w_addr] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_cmd <= i_cmd_bit;
            r_last   <= i_last;
            r_sample <= i_sample;
            r_fnum   <= i_frame_number;
        end
    end

    afm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ((w_sum > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum[SUM_W-1:0]),
        .i_den   (SUM_W'(r_count == COUNT_MAX ? r_count : r_count + 1'b1)),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_mean = (w_quo > SUM_W'(MEAN_CAP)) ? MEAN_CAP : w_quo[MAG_W-1:0];
    assign w_long = (CNT_W'(r_count) > CNT_W'(r_max_samples))
                 || (CNT_W'(r_count) > CNT_W'(FRAME_STORE_DEPTH))
                 || (r_count >= COUNT_MAX);
    assign w_rep  = (CNT_W'(r_count) == CNT_W'(r_prev_len))
                 && (r_peak >= r_min_peak) && (r_prev_peak >= r_min_peak) && !r_mis;
    assign w_run_inc = r_run + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_peak    <= 16'd128;
            r_max_samples <= 11'd1024;
            r_prev_len    <= '0;
            r_prev_peak   <= '0;
            r_run         <= '0;
            r_count       <= '0;
            r_sum         <= '0;
            r_peak        <= '0;
            r_mis         <= 1'b0;
            r_rep         <= 1'b0;
            r_tot_f       <= '0;
            r_win_f       <= '0;
            r_tot_r       <= '0;
            r_win_r       <= '0;
            r_win_run     <= '0;
            r_seq         <= '0;
            r_mean        <= '0;
            r_rpeak       <= '0;
            r_win_mean    <= '0;
            r_win_peak    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_PEAK) begin
                    r_min_peak <= i_cfg_data;
                end else begin
                    r_max_samples <= i_cfg_data[10:0];
                end
            end
            if (i_cmd.load && i_cmd_bit) begin
                r_rep <= (r_run != '0);
            end
            if (i_cmd.sample_go) begin
                if (w_in_store && r_rd != r_sample) begin
                    r_mis <= 1'b1;
                end
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
                r_sum <= (w_sum > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum[SUM_W-1:0];
                if (w_mag > r_peak) begin
                    r_peak <= w_mag;
                end
            end
            if (i_cmd.frame_go) begin
                r_tot_f <= r_tot_f + 1'b1;
                r_win_f <= r_win_f + 1'b1;
                r_seq   <= r_fnum;
                r_mean  <= w_mean;
                r_rpeak <= r_peak;
                if (w_mean > r_win_mean) r_win_mean <= w_mean;
                if (r_peak > r_win_peak) r_win_peak <= r_peak;
                r_rep <= !w_long && w_rep;
                if (w_long) begin
                    r_prev_len  <= '0;
                    r_prev_peak <= '0;
                    r_run       <= '0;
                end else begin
                    if (w_rep) begin
                        r_run   <= w_run_inc;
                        r_tot_r <= r_tot_r + 1'b1;
                        r_win_r <= r_win_r + 1'b1;
                        if (w_run_inc > r_win_run) r_win_run <= w_run_inc;
                    end else begin
                        r_run <= '0;
                    end
                    r_prev_len  <= r_count[10:0];
                    r_prev_peak <= r_peak;
                end
                r_count <= '0;
                r_sum   <= '0;
                r_peak  <= '0;
                r_mis   <= 1'b0;
            end
            if (i_cmd.report) begin
                r_win_f    <= '0;
                r_win_r    <= '0;
                r_win_run  <= '0;
                r_win_mean <= '0;
                r_win_peak <= '0;
            end
        end
    end

    assign o_status.is_cmd   = r_is_cmd;
    assign o_status.is_last  = r_last;
    assign o_status.div_done = w_done;

    assign o_result = '{
        seq_of_frame:    r_seq,
        mean_magnitude:  r_mean,
        peak_magnitude:  r_rpeak,
        is_repeat:       r_rep,
        repeat_run:      r_run,
        total_frames:    r_tot_f,
        window_frames:   r_win_f,
        total_repeats:   r_tot_r,
        window_repeats:  r_win_r,
        window_run_max:  r_win_run,
        window_mean_max: r_win_mean,
        window_peak_max: r_win_peak
    };

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import afm_pkg::*;

    typedef struct packed {
        logic [31:0] seq_of_frame;
        logic [15:0] mean_magnitude;
        logic [15:0] peak_magnitude;
        logic        is_repeat;
        logic [31:0] repeat_run;
        logic [31:0] total_frames;
        logic [31:0] window_frames;
        logic [31:0] total_repeats;
        logic [31:0] window_repeats;
        logic [31:0] window_run_max;
        logic [15:0] window_mean_max;
        logic [15:0] window_peak_max;
    } frame_stats_t;

    class frame_scoreboard;
        logic [15:0] min_peak;
        logic [10:0] max_samples;
        logic [15:0] prev_frame [1024];
        int unsigned prev_len, prev_peak, run_len;
        int unsigned cur_count, cur_sum, cur_peak;
        bit          cur_mismatch;
        int unsigned tot_frames, win_frames, tot_reps, win_reps, win_run_max;
        int unsigned last_seq, last_mean, last_peak, win_mean_max, win_peak_max;
        frame_stats_t pending [$];
        int errors;

        function void clear_all();
            min_peak = 16'd128;
            max_samples = 11'd1024;
            foreach (prev_frame[i]) prev_frame[i] = '0;
            prev_len = 0; prev_peak = 0; run_len = 0;
            cur_count = 0; cur_sum = 0; cur_peak = 0; cur_mismatch = 0;
            tot_frames = 0; win_frames = 0; tot_reps = 0; win_reps = 0;
            win_run_max = 0; last_seq = 0; last_mean = 0; last_peak = 0;
            win_mean_max = 0; win_peak_max = 0;
            errors = 0;
        endfunction

        function void snapshot(bit rep);
            frame_stats_t r;
            r.seq_of_frame = last_seq;
            r.mean_magnitude = last_mean[15:0];
            r.peak_magnitude = last_peak[15:0];
            r.is_repeat = rep;
            r.repeat_run = run_len;
            r.total_frames = tot_frames;
            r.window_frames = win_frames;
            r.total_repeats = tot_reps;
            r.window_repeats = win_reps;
            r.window_run_max = win_run_max;
            r.window_mean_max = win_mean_max[15:0];
            r.window_peak_max = win_peak_max[15:0];
            pending.push_back(r);
        endfunction

        function void note_beat(bit cmd, logic [15:0] smp, bit last, logic [31:0] seq);
            int unsigned mag, mean, len;
            bit rep;
            if (cmd) begin
                snapshot(run_len != 0);
                win_frames = 0; win_reps = 0; win_run_max = 0;
                win_mean_max = 0; win_peak_max = 0;
                return;
            end
            mag = smp[15] ? (32'h10000 - smp) : smp;
            if (cur_count < 1024) begin
                if (prev_frame[cur_count] != smp) cur_mismatch = 1;
                prev_frame[cur_count] = smp;
            end
            if (cur_count < 65535) cur_count++;
            cur_sum = (cur_sum > 32'h7FFFFFFF - mag) ? 32'h7FFFFFFF : cur_sum + mag;
            if (mag > cur_peak) cur_peak = mag;
            if (!last) return;
            len = cur_count;
            mean = cur_sum / len;
            if (mean > 32768) mean = 32768;
            rep = 0;
            tot_frames++; win_frames++;
            last_seq = seq; last_mean = mean; last_peak = cur_peak;
            if (mean > win_mean_max) win_mean_max = mean;
            if (cur_peak > win_peak_max) win_peak_max = cur_peak;
            if (len > max_samples || len > 1024 || len >= 65535) begin
                prev_len = 0; prev_peak = 0; run_len = 0;
            end else begin
                if (prev_len == len && cur_peak >= min_peak && prev_peak >= min_peak
                    && !cur_mismatch) begin
                    rep = 1;
                    run_len++; tot_reps++; win_reps++;
                    if (run_len > win_run_max) win_run_max = run_len;
                end else begin
                    run_len = 0;
                end
                prev_len = len; prev_peak = cur_peak;
            end
            cur_count = 0; cur_sum = 0; cur_peak = 0; cur_mismatch = 0;
            snapshot(rep);
        endfunction

        function void check_result(frame_stats_t got);
            frame_stats_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.seq_of_frame !== e.seq_of_frame) begin
                $error("seq_of_frame exp %0d got %0d", e.seq_of_frame, got.seq_of_frame); errors++;
            end
            if (got.mean_magnitude !== e.mean_magnitude) begin
                $error("mean_magnitude exp %0d got %0d", e.mean_magnitude, got.mean_magnitude);
                errors++;
            end
            if (got.peak_magnitude !== e.peak_magnitude) begin
                $error("peak_magnitude exp %0d got %0d", e.peak_magnitude, got.peak_magnitude);
                errors++;
            end
            if (got.is_repeat !== e.is_repeat) begin
                $error("is_repeat exp %0d got %0d", e.is_repeat, got.is_repeat); errors++;
            end
            if (got.repeat_run !== e.repeat_run) begin
                $error("repeat_run exp %0d got %0d", e.repeat_run, got.repeat_run); errors++;
            end
            if (got.total_frames !== e.total_frames) begin
                $error("total_frames exp %0d got %0d", e.total_frames, got.total_frames); errors++;
            end
            if (got.window_frames !== e.window_frames) begin
                $error("window_frames exp %0d got %0d", e.window_frames, got.window_frames);
                errors++;
            end
            if (got.total_repeats !== e.total_repeats) begin
                $error("total_repeats exp %0d got %0d", e.total_repeats, got.total_repeats);
                errors++;
            end
            if (got.window_repeats !== e.window_repeats) begin
                $error("window_repeats exp %0d got %0d", e.window_repeats, got.window_repeats);
                errors++;
            end
            if (got.window_run_max !== e.window_run_max) begin
                $error("window_run_max exp %0d got %0d", e.window_run_max, got.window_run_max);
                errors++;
            end
            if (got.window_mean_max !== e.window_mean_max) begin
                $error("window_mean_max exp %0d got %0d", e.window_mean_max,
                       got.window_mean_max);
                errors++;
            end
            if (got.window_peak_max !== e.window_peak_max) begin
                $error("window_peak_max exp %0d got %0d", e.window_peak_max,
                       got.window_peak_max);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [295:0] m_axis_tdata;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 0;
    logic [15:0]  i_cfg_data = '0;

    frame_scoreboard sb;
    logic [15:0]  pattern [$];

    audio_frame_level_and_repeat_monitor dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic frame_stats_t unpack_result(logic [295:0] d);
        frame_stats_t r;
        int p;
        p = 0;
        r.seq_of_frame    = d[p +: 32]; p += 32;
        r.mean_magnitude  = d[p +: 16]; p += 16;
        r.peak_magnitude  = d[p +: 16]; p += 16;
        r.is_repeat       = d[p];       p += 1;
        r.repeat_run      = d[p +: 32]; p += 32;
        r.total_frames    = d[p +: 32]; p += 32;
        r.window_frames   = d[p +: 32]; p += 32;
        r.total_repeats   = d[p +: 32]; p += 32;
        r.window_repeats  = d[p +: 32]; p += 32;
        r.window_run_max  = d[p +: 32]; p += 32;
        r.window_mean_max = d[p +: 16]; p += 16;
        r.window_peak_max = d[p +: 16];
        return r;
    endfunction

    task automatic send_beat(bit cmd, logic [15:0] smp, bit last, logic [31:0] seq);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {seq, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(cmd, smp, last, seq);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MIN_PEAK) sb.min_peak = val;
        else sb.max_samples = val[10:0];
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_frame(int len, bit reuse, logic [31:0] seq);
        logic [15:0] s;
        if (!reuse) begin
            pattern.delete();
            for (int i = 0; i < len; i++) begin
                s = 16'($urandom());
                if ($urandom_range(0, 3) == 0) s = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
                pattern.push_back(s);
            end
        end
        for (int i = 0; i < pattern.size(); i++)
            send_beat(0, pattern[i], i == pattern.size() - 1, seq);
    endtask

    always begin : p_sink
        int k;
        @(negedge i_clk);
        k = $urandom_range(0, 8);
        if (k != 0) begin
            m_axis_tready <= 0;
            repeat (k) @(negedge i_clk);
        end
        m_axis_tready <= 1;
        do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(unpack_result(m_axis_tdata));

    initial begin
        int n;
        int len;
        sb = new();
        sb.clear_all();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_beat(1, 16'h0, 0, 32'h0);
        send_beat(0, 16'h8000, 1, 32'hFFFFFFFF);
        send_beat(0, 16'h8000, 1, 32'h0);
        send_beat(0, 16'h7FFF, 0, 32'h1);
        send_beat(0, 16'hFFFF, 1, 32'h2);
        send_beat(0, 16'h7FFF, 0, 32'h3);
        send_beat(0, 16'hFFFF, 1, 32'h4);
        send_beat(0, 16'h0001, 0, 32'h5);
        send_beat(0, 16'h0000, 1, 32'h6);
        send_beat(1, 16'hFFFF, 1, 32'hFFFFFFFF);
        send_beat(0, 16'h0005, 0, 32'h7);
        send_beat(1, 16'h1234, 0, 32'h8);
        send_beat(0, 16'h0005, 1, 32'h9);
        wait_drained();

        write_reg(CFG_MIN_PEAK, 16'd0);
        write_reg(CFG_MAX_SAMPLES, 16'd1);
        send_beat(0, 16'h0000, 1, 32'hA);
        send_beat(0, 16'h0000, 1, 32'hB);
        send_beat(0, 16'h0000, 0, 32'hC);
        send_beat(0, 16'h0000, 1, 32'hD);
        send_beat(1, 16'h0, 0, 32'h0);
        wait_drained();

        write_reg(CFG_MAX_SAMPLES, 16'd0);
        send_beat(0, 16'h0000, 1, 32'hE);
        send_beat(0, 16'h0000, 1, 32'hF);
        wait_drained();

        write_reg(CFG_MIN_PEAK, 16'd32768);
        write_reg(CFG_MAX_SAMPLES, 16'd1024);
        send_frame(3, 0, $urandom());
        send_frame(3, 1, $urandom());
        send_frame(3, 1, $urandom());
        wait_drained();

        n = 0;
        while (n < 500) begin
            if (n == 250) begin
                wait_drained();
                write_reg(CFG_MIN_PEAK, ($urandom_range(0, 3) == 0) ? 16'hFFFF
                          : 16'($urandom_range(0, 400)));
                write_reg(CFG_MAX_SAMPLES, ($urandom_range(1, 2) == 1) ? 16'h7FF
                          : 16'($urandom_range(2, 12)));
            end
            case ($urandom_range(0, 9))
                0: begin
                    send_beat(1, 16'($urandom()), 1'($urandom_range(0, 1)), $urandom());
                    n++;
                end
                1, 2: begin
                    len = $urandom_range(1, 12);
                    send_frame(len, 0, $urandom());
                    n += len;
                end
                default: begin
                    if (pattern.size() == 0) len = $urandom_range(1, 8);
                    else len = pattern.size();
                    send_frame(len, pattern.size() != 0, $urandom());
                    n += len;
                end
            endcase
        end
        send_beat(1, 16'h0, 0, 32'h0);

        wait_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
